// ===== hw/rtl/kf_pkg.sv =====
// Package for the scalar Kalman filter: shared types, register codes and
// fixed-point constants. Used by every module of the block.

package kf_pkg;

	localparam int KF_FRAC_BITS = 16;
	localparam int KF_DATA_W    = 24;

	localparam logic [KF_DATA_W-1:0] KF_COV_MAX  = 24'hFFFFFF;
	localparam logic [KF_DATA_W-1:0] KF_PN_RESET = 24'd655;
	localparam logic [KF_DATA_W-1:0] KF_MN_RESET = 24'd6554;

	localparam logic signed [KF_DATA_W+2:0] KF_EST_MAX = 27'sd8388607;
	localparam logic signed [KF_DATA_W+2:0] KF_EST_MIN = -27'sd8388608;

	typedef enum logic [0:0] {
		REG_PROCESS_NOISE     = 1'b0,
		REG_MEASUREMENT_NOISE = 1'b1
	} kf_reg_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV,
		ST_GAIN,
		ST_MUL,
		ST_DONE
	} kf_state_t;

	typedef struct packed {
		logic load;
		logic step;
	} kf_seq_t;

endpackage

// ===== hw/rtl/kf_div.sv =====
// Restoring divider producing one quotient bit per cycle while seq.step is high, for the filter gain.
// Depends on kf_pkg for the sequencing struct.

module kf_div import kf_pkg::*; #(
	parameter int FRAC_BITS = KF_FRAC_BITS
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  kf_seq_t                  seq,
	input  logic [KF_DATA_W-1:0]     dividend,
	input  logic [KF_DATA_W:0]       divisor,
	output logic [FRAC_BITS:0]       quotient
);

	logic [KF_DATA_W:0]   rem_q;
	logic [KF_DATA_W:0]   dvs_q;
	logic [FRAC_BITS:0]   quo_q;
	logic                 first_q;
	logic [KF_DATA_W+1:0] trial;
	logic [KF_DATA_W+1:0] diff;
	logic                 ge;

	assign trial = first_q ? {1'b0, rem_q} : {rem_q, 1'b0};
	assign ge    = trial >= {1'b0, dvs_q};
	assign diff  = trial - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_q <= 1'b0;
		end else if (seq.load) begin
			first_q <= 1'b1;
		end else if (seq.step) begin
			first_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (seq.load) begin
			rem_q <= {1'b0, dividend};
			dvs_q <= divisor;
			quo_q <= '0;
		end else if (seq.step) begin
			rem_q <= ge ? diff[KF_DATA_W:0] : trial[KF_DATA_W:0];
			quo_q <= {quo_q[FRAC_BITS-1:0], ge};
		end
	end

	assign quotient = quo_q;

endmodule

// ===== hw/rtl/kf_mac.sv =====
// Bit-serial shift-add multiplier that returns the product floored by
// 2^FRAC_BITS, consuming one multiplier bit per cycle while seq.step is high. Depends on kf_pkg.

module kf_mac import kf_pkg::*; #(
	parameter int FRAC_BITS = KF_FRAC_BITS,
	parameter int MW        = KF_DATA_W + 1
) (
	input  logic                  clk,
	input  kf_seq_t               seq,
	input  logic                  last,
	input  logic [FRAC_BITS:0]    multiplier,
	input  logic signed [MW-1:0]  multiplicand,
	output logic signed [MW:0]    product
);

	logic [FRAC_BITS:0]   mpy_q;
	logic signed [MW-1:0] mcand_q;
	logic signed [MW:0]   acc_q;
	logic signed [MW:0]   addend;
	logic signed [MW:0]   sum;

	assign addend = mpy_q[0] ? {mcand_q[MW-1], mcand_q} : '0;
	assign sum    = acc_q + addend;

	always_ff @(posedge clk) begin
		if (seq.load) begin
			mpy_q   <= multiplier;
			mcand_q <= multiplicand;
			acc_q   <= '0;
		end else if (seq.step) begin
			mpy_q <= mpy_q >> 1;
			acc_q <= last ? sum : (sum >>> 1);
		end
	end

	assign product = acc_q;

endmodule

// ===== hw/rtl/scalar_kalman_filter.sv =====
// Scalar Kalman filter top level: stream ports, configuration registers,
// filter state and the step sequencer. Depends on kf_pkg, kf_div and kf_mac.
//
// Usage: each sample request on the slave stream runs one filter step and
// yields one estimate request on the master stream. Noise registers are
// written through the plain write port while the block is idle; this is a
// rule for the user that the block itself does not enforce. A sample is
// taken only when the sequencer is idle. The gain divider then runs, the
// gain state loads the gain and its complement into the two serial
// multipliers, and these run one bit of each per cycle. The estimate is
// registered in the done state once the output register is free, and the
// next sample can be taken in the cycle after that, so the block takes no
// new sample until the previous step is finished.
// The output register lets a new sample be accepted while the previous
// estimate waits. If the receiver stalls, the finished step holds until the
// output register is free and the filter state is updated only then.
// Reset loads the default noise values, a zero estimate and a covariance of
// one, and leaves both streams empty.

module scalar_kalman_filter import kf_pkg::*; #(
	parameter int FRACTION_BITS = KF_FRAC_BITS
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_tvalid,
	output logic                        s_tready,
	input  logic signed [KF_DATA_W-1:0] s_tdata,   // sample
	output logic                        m_tvalid,
	input  logic                        m_tready,
	output logic signed [KF_DATA_W-1:0] m_tdata,   // estimate
	input  logic                        cfg_wr_en,
	input  logic [0:0]                  cfg_addr,
	input  logic [KF_DATA_W-1:0]        cfg_wdata
);

	localparam int CW = $clog2(FRACTION_BITS + 1);
	localparam logic [CW-1:0] CNT_LAST = CW'(FRACTION_BITS);
	localparam logic [FRACTION_BITS:0] ONE_G = (FRACTION_BITS + 1)'(1) << FRACTION_BITS;
	localparam logic [KF_DATA_W-1:0] COV_RESET = (FRACTION_BITS >= KF_DATA_W) ?
		KF_COV_MAX : KF_DATA_W'(ONE_G);

	kf_state_t state_q, state_d;
	logic [CW-1:0] cnt_q;

	logic [KF_DATA_W-1:0] pn_q, mn_q;
	logic signed [KF_DATA_W-1:0] last_est_q;
	logic [KF_DATA_W-1:0] last_cov_q;

	logic [KF_DATA_W-1:0]        p_pred_q;
	logic                        denom_zero_q;
	logic signed [KF_DATA_W:0]   innov_q;

	logic [KF_DATA_W:0]          cov_sum;
	logic [KF_DATA_W-1:0]        p_pred;
	logic [KF_DATA_W:0]          denom;
	logic signed [KF_DATA_W:0]   innov;

	logic                        out_valid_q;
	logic signed [KF_DATA_W-1:0] out_q;

	logic                        in_fire, out_free, done_fire, mul_last;
	kf_seq_t                     div_seq, mac_seq;
	logic [FRACTION_BITS:0]      quotient, gain, comp;
	logic signed [KF_DATA_W+1:0] acc_est, acc_cov;
	logic signed [KF_DATA_W+2:0] est_wide;
	logic signed [KF_DATA_W-1:0] est_next;

	assign cov_sum = {1'b0, last_cov_q} + {1'b0, pn_q};
	assign p_pred  = cov_sum[KF_DATA_W] ? KF_COV_MAX : cov_sum[KF_DATA_W-1:0];
	assign denom   = {1'b0, p_pred} + {1'b0, mn_q};
	assign innov   = {s_tdata[KF_DATA_W-1], s_tdata} - {last_est_q[KF_DATA_W-1], last_est_q};

	assign in_fire   = s_tvalid && s_tready;
	assign out_free  = !out_valid_q || m_tready;
	assign mul_last  = cnt_q == CNT_LAST;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pn_q <= KF_PN_RESET;
			mn_q <= KF_MN_RESET;
		end else if (cfg_wr_en) begin
			unique case (kf_reg_t'(cfg_addr))
				REG_PROCESS_NOISE:     pn_q <= cfg_wdata;
				REG_MEASUREMENT_NOISE: mn_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (s_tvalid) state_d = ST_DIV;
			ST_DIV:  if (mul_last) state_d = ST_GAIN;
			ST_GAIN: state_d = ST_MUL;
			ST_MUL:  if (mul_last) state_d = ST_DONE;
			ST_DONE: if (out_free) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		s_tready     = 1'b0;
		div_seq      = '0;
		mac_seq      = '0;
		done_fire    = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				s_tready     = 1'b1;
				div_seq.load = s_tvalid;
			end
			ST_DIV:  div_seq.step = 1'b1;
			ST_GAIN: mac_seq.load = 1'b1;
			ST_MUL:  mac_seq.step = 1'b1;
			ST_DONE: done_fire = out_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_q != state_d) begin
				cnt_q <= '0;
			end else if (state_q == ST_DIV || state_q == ST_MUL) begin
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			p_pred_q     <= p_pred;
			denom_zero_q <= denom == '0;
			innov_q      <= innov;
		end
	end

	kf_div #(
		.FRAC_BITS (FRACTION_BITS)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.seq      (div_seq),
		.dividend (p_pred),
		.divisor  (denom),
		.quotient (quotient)
	);

	assign gain = denom_zero_q ? '0 : quotient;
	assign comp = ONE_G - gain;

	kf_mac #(
		.FRAC_BITS (FRACTION_BITS),
		.MW        (KF_DATA_W + 1)
	) u_mac_est (
		.clk          (clk),
		.seq          (mac_seq),
		.last         (mul_last),
		.multiplier   (gain),
		.multiplicand (innov_q),
		.product      (acc_est)
	);

	kf_mac #(
		.FRAC_BITS (FRACTION_BITS),
		.MW        (KF_DATA_W + 1)
	) u_mac_cov (
		.clk          (clk),
		.seq          (mac_seq),
		.last         (mul_last),
		.multiplier   (comp),
		.multiplicand ($signed({1'b0, p_pred_q})),
		.product      (acc_cov)
	);

	assign est_wide = {{3{last_est_q[KF_DATA_W-1]}}, last_est_q}
		+ {acc_est[KF_DATA_W+1], acc_est};

	always_comb begin
		if (est_wide > KF_EST_MAX) begin
			est_next = KF_EST_MAX[KF_DATA_W-1:0];
		end else if (est_wide < KF_EST_MIN) begin
			est_next = KF_EST_MIN[KF_DATA_W-1:0];
		end else begin
			est_next = est_wide[KF_DATA_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_est_q  <= '0;
			last_cov_q  <= COV_RESET;
			out_valid_q <= 1'b0;
		end else if (done_fire) begin
			last_est_q  <= est_next;
			last_cov_q  <= acc_cov[KF_DATA_W-1:0];
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (done_fire) begin
			out_q <= est_next;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_q;

	a_accept_starts_div: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |=> state_q == ST_DIV)
		else $error("accepted sample did not start the divider");

	a_gain_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_GAIN |-> gain <= ONE_G)
		else $error("gain exceeds one");

	a_cov_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DONE |-> (acc_cov >= 0 && acc_cov <= $signed({2'b00, p_pred_q})))
		else $error("updated covariance outside the predicted range");

	a_zero_denom_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE && denom_zero_q) |-> est_next == last_est_q)
		else $error("estimate moved with a zero gain denominator");

endmodule

// ===== test/kf_checker.sv =====
// Checker for the scalar Kalman filter: watches the noise writes and both streams,
// predicts every estimate from its own copy of the filter state and compares.
// Depends on kf_pkg.

module kf_checker import kf_pkg::*; (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_tvalid,
	input  logic                        s_tready,
	input  logic signed [KF_DATA_W-1:0] s_tdata,
	input  logic                        m_tvalid,
	input  logic                        m_tready,
	input  logic signed [KF_DATA_W-1:0] m_tdata,
	input  logic                        cfg_wr_en,
	input  logic [0:0]                  cfg_addr,
	input  logic [KF_DATA_W-1:0]        cfg_wdata,
	output int                          errors,
	output int                          pending
);

	localparam longint UNITY     = longint'(1) << KF_FRAC_BITS;
	localparam longint COV_LIMIT = (longint'(1) << KF_DATA_W) - 1;
	localparam longint EST_HIGH  = (longint'(1) << (KF_DATA_W - 1)) - 1;
	localparam longint EST_LOW   = -(longint'(1) << (KF_DATA_W - 1));

	logic [KF_DATA_W-1:0]        process_noise;
	logic [KF_DATA_W-1:0]        measurement_noise;
	logic [KF_DATA_W-1:0]        covariance;
	logic signed [KF_DATA_W-1:0] estimate;
	logic signed [KF_DATA_W-1:0] estimate_q[$];
	int                          fail_count;

	// One filter step: predict, gain by truncating division, correct and
	// update the covariance. The arithmetic right shift floors the correction.
	function automatic logic signed [KF_DATA_W-1:0] filter_step(
		input logic signed [KF_DATA_W-1:0] z
	);
		longint p_pred;
		longint denom;
		longint gain;
		longint innov;
		longint est_next;
		longint p_next;
		p_pred = longint'(covariance) + longint'(process_noise);
		if (p_pred > COV_LIMIT) begin
			p_pred = COV_LIMIT;
		end
		denom = p_pred + longint'(measurement_noise);
		gain = (denom == 0) ? 0 : (p_pred << KF_FRAC_BITS) / denom;
		if (gain > UNITY) begin
			gain = UNITY;
		end
		innov = longint'(z) - longint'(estimate);
		est_next = longint'(estimate) + ((gain * innov) >>> KF_FRAC_BITS);
		if (est_next > EST_HIGH) begin
			est_next = EST_HIGH;
		end
		if (est_next < EST_LOW) begin
			est_next = EST_LOW;
		end
		p_next = ((UNITY - gain) * p_pred) >> KF_FRAC_BITS;
		if (p_next > COV_LIMIT) begin
			p_next = COV_LIMIT;
		end
		estimate = est_next[KF_DATA_W-1:0];
		covariance = p_next[KF_DATA_W-1:0];
		return estimate;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		logic signed [KF_DATA_W-1:0] want;
		if (!arst_n) begin
			process_noise = KF_PN_RESET;
			measurement_noise = KF_MN_RESET;
			covariance = KF_DATA_W'(UNITY);
			estimate = '0;
			estimate_q.delete();
			fail_count = 0;
			errors <= 0;
			pending <= 0;
		end else begin
			if (cfg_wr_en) begin
				case (kf_reg_t'(cfg_addr))
					REG_PROCESS_NOISE: begin
						process_noise = cfg_wdata;
					end
					REG_MEASUREMENT_NOISE: begin
						measurement_noise = cfg_wdata;
					end
					default: begin
					end
				endcase
			end
			if (m_tvalid && m_tready) begin
				if (estimate_q.size() == 0) begin
					fail_count++;
					if (fail_count <= 10) begin
						$display("estimate %0d arrived with none expected", m_tdata);
					end
				end else begin
					want = estimate_q.pop_front();
					if (m_tdata !== want) begin
						fail_count++;
						if (fail_count <= 10) begin
							$display("estimate mismatch: expected %0d, got %0d",
								want, m_tdata);
						end
					end
				end
			end
			if (s_tvalid && s_tready) begin
				estimate_q.push_back(filter_step(s_tdata));
			end
			errors <= fail_count;
			pending <= estimate_q.size();
		end
	end

endmodule

// ===== test/tb.sv =====
// Testbench top for the scalar Kalman filter: clock, reset, sample requests,
// noise register writes and the verdict. Depends on kf_pkg, kf_checker and the block.

module tb import kf_pkg::*;;

	localparam logic signed [KF_DATA_W-1:0] SAMPLE_MAX = 24'sh7FFFFF;
	localparam logic signed [KF_DATA_W-1:0] SAMPLE_MIN = 24'sh800000;
	localparam int                          SETTLE_CYCLES = 2 * KF_FRAC_BITS + 8;

	logic                        clk = 1'b0;
	logic                        arst_n;
	logic                        s_tvalid;
	logic                        s_tready;
	logic signed [KF_DATA_W-1:0] s_tdata;
	logic                        m_tvalid;
	logic                        m_tready;
	logic signed [KF_DATA_W-1:0] m_tdata;
	logic                        cfg_wr_en;
	logic [0:0]                  cfg_addr;
	logic [KF_DATA_W-1:0]        cfg_wdata;
	int                          errors;
	int                          pending;
	logic                        idle_on;
	logic signed [KF_DATA_W-1:0] last_sample;

	scalar_kalman_filter i_dut (.*);

	kf_checker i_check (.*);

	initial begin
		forever #6 clk = ~clk;
	end

	initial begin
		#(12 * 2_000_000);
		$display("tb NOT OK");
		$finish;
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			m_tready <= !idle_on || ($urandom_range(99) >= 29);
		end
	end

	task automatic send_sample(input logic signed [KF_DATA_W-1:0] value);
		int gap;
		gap = 0;
		if (idle_on && $urandom_range(99) < 29) begin
			gap = $urandom_range(1, 45);
		end
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= value;
		@(negedge clk);
		while (!s_tready) @(negedge clk);
		@(posedge clk);
		last_sample = value;
	endtask

	// Stops requests and waits until every estimate has come back and the
	// sequencer has had time to go idle.
	task automatic settle_filter();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_noise(input logic [KF_DATA_W-1:0] pn, input logic [KF_DATA_W-1:0] mn);
		cfg_wr_en <= 1'b1;
		cfg_addr <= REG_PROCESS_NOISE;
		cfg_wdata <= pn;
		@(posedge clk);
		cfg_addr <= REG_MEASUREMENT_NOISE;
		cfg_wdata <= mn;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	function automatic logic [KF_DATA_W-1:0] pick_noise();
		logic [KF_DATA_W-1:0] value;
		case ($urandom_range(5))
			0: value = '0;
			1: value = KF_COV_MAX;
			2: value = KF_DATA_W'($urandom_range(1, 255));
			3: value = KF_DATA_W'($urandom_range(256, 131071));
			default: value = KF_DATA_W'($urandom);
		endcase
		return value;
	endfunction

	// In half the draws a slowly moving signal around the last sample, otherwise jumps and extremes.
	function automatic logic signed [KF_DATA_W-1:0] next_sample();
		int                          delta;
		logic signed [KF_DATA_W-1:0] value;
		delta = int'($urandom_range(0, 8191)) - 4096;
		case ($urandom_range(9))
			0: value = SAMPLE_MAX;
			1: value = SAMPLE_MIN;
			2, 3, 4: value = KF_DATA_W'($urandom);
			default: value = last_sample + delta[KF_DATA_W-1:0];
		endcase
		return value;
	endfunction

	initial begin
		int ph;
		int k;
		arst_n <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata <= '0;
		cfg_wr_en <= 1'b0;
		cfg_addr <= REG_PROCESS_NOISE;
		cfg_wdata <= '0;
		idle_on <= 1'b1;
		last_sample = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_sample(SAMPLE_MAX);
		send_sample(SAMPLE_MIN);
		send_sample(24'sd0);
		send_sample(-24'sd1);
		send_sample(24'sd1);
		send_sample(SAMPLE_MIN);
		send_sample(SAMPLE_MAX);

		// Zero measurement noise gives a gain of one and a zero covariance; with
		// zero process noise the following steps see a zero denominator.
		settle_filter();
		write_noise('0, '0);
		send_sample(24'sd12345);
		send_sample(SAMPLE_MAX);
		send_sample(SAMPLE_MIN);
		send_sample(24'sd0);

		settle_filter();
		write_noise(KF_COV_MAX, '0);
		send_sample(SAMPLE_MIN);
		send_sample(SAMPLE_MAX);

		settle_filter();
		write_noise(KF_COV_MAX, KF_COV_MAX);
		send_sample(SAMPLE_MAX);
		send_sample(SAMPLE_MIN);
		send_sample(SAMPLE_MAX);

		settle_filter();
		write_noise(24'd1, KF_COV_MAX);
		send_sample(SAMPLE_MIN);
		send_sample(SAMPLE_MAX);

		for (ph = 0; ph < 8; ph++) begin
			settle_filter();
			if (ph == 0) begin
				write_noise(KF_PN_RESET, KF_MN_RESET);
			end else begin
				write_noise(pick_noise(), pick_noise());
			end
			idle_on <= (ph != 3);
			for (k = 0; k < 75; k++) begin
				if ($urandom_range(59) == 0) begin
					settle_filter();
				end
				send_sample(next_sample());
			end
		end

		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (errors == 0 && pending == 0) begin
			$display("tb OK");
		end else begin
			$display("tb NOT OK");
		end
		$finish;
	end

endmodule
